// ===== rtl/core/pf_pkg.sv =====
// pf_pkg: shared types, constants and helpers for the Playfair encryptor.
// No dependencies; imported by every module under rtl/core.
package pf_pkg;

    localparam int CELL_COUNT = 25;
    localparam int CELL_SIDE  = 5;
    localparam int ALPHA_SIZE = 26;
    localparam int ADDR_W     = 3;

    typedef logic [4:0] letter_t;
    typedef logic [4:0] idx_t;
    typedef logic [2:0] coord_t;

    localparam letter_t LETTER_I      = 5'd8;
    localparam letter_t LETTER_J      = 5'd9;
    localparam letter_t LETTER_Z      = 5'd25;
    localparam letter_t LETTER_LIMIT  = 5'd26;
    localparam letter_t DOLLAR_MARK   = 5'd26;
    localparam letter_t FILLER_RESET  = 5'd23;

    // only J marked
    localparam logic [ALPHA_SIZE-1:0] USED_INIT = 26'h000_0200;

    localparam logic [ADDR_W-3:0] REG_FILLER = 1'b0;

    typedef enum logic [2:0] {
        ACT_CLEAR  = 3'd0,
        ACT_KEY    = 3'd1,
        ACT_FINISH = 3'd2,
        ACT_TEXT   = 3'd3,
        ACT_END    = 3'd4
    } action_t;

    typedef struct packed {
        logic    clear;
        logic    load;
        letter_t letter;
    } cell_cmd_t;

    typedef struct packed {
        letter_t find_a;
        letter_t find_b;
        idx_t    rd_x;
        idx_t    rd_y;
    } query_t;

    typedef struct packed {
        logic    valid;
        logic    match_a;
        logic    match_b;
        letter_t x_data;
        letter_t y_data;
    } cell_out_t;

    typedef struct packed {
        coord_t row;
        coord_t col;
    } pos_t;

    typedef struct packed {
        pos_t    pos_a;
        pos_t    pos_b;
        letter_t x_data;
        letter_t y_data;
        logic    full;
    } chain_res_t;

    function automatic coord_t wrap_inc(input coord_t v);
        return (v == coord_t'(CELL_SIDE - 1)) ? 3'd0 : v + 3'd1;
    endfunction

    function automatic idx_t cell_index(input coord_t r, input coord_t c);
        return idx_t'({r, 2'b00}) + idx_t'(r) + idx_t'(c);
    endfunction

endpackage

// ===== rtl/core/playfair_encryptor_top.sv =====
// playfair_encryptor_top: Playfair key square builder and pair encryptor.
// Depends on pf_pkg, pf_chain, pf_cell.
//
// Input stream: tuser carries the action (clear key, key letter, finish
// square, text letter, end of text), tdata the letter index A=0..Z=25.
// Output stream: tdata carries the cipher letter (26 = doubled-letter '$'),
// tlast marks the second letter of each pair.
// APB register 0 (byte address 0) holds the filler letter, reset X.
//
// One word is in work at a time. Clear, key letter and a first text letter
// take effect at their accept. Finish square sweeps the alphabet through
// the cell row. A completed pair runs lookup (ST_FIND) then cell read
// (ST_SELECT), each registered, then shows its first cipher letter in
// ST_OUT0 and its second in ST_OUT1. The lookup compares all 25 cells
// at once; the sweep costs one letter per cycle.
// Reset empties the square, marks only J used, drops any held letter.
// A stalled receiver holds the current output word; no input is taken
// until both letters of the pair are delivered.
module playfair_encryptor_top (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      s_axis_tvalid,
    output logic                      s_axis_tready,
    input  logic [7:0]                s_axis_tdata,   // [4:0] letter
    input  logic [2:0]                s_axis_tuser,   // [2:0] action
    output logic                      m_axis_tvalid,
    input  logic                      m_axis_tready,
    output logic [7:0]                m_axis_tdata,   // [4:0] cipher_letter
    output logic                      m_axis_tlast,
    input  logic                      psel,
    input  logic                      penable,
    input  logic                      pwrite,
    input  logic [pf_pkg::ADDR_W-1:0] paddr,
    input  logic [31:0]               pwdata,
    output logic [31:0]               prdata,
    output logic                      pready
);
    import pf_pkg::*;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_FILL,
        ST_FIND,
        ST_SELECT,
        ST_OUT0,
        ST_OUT1
    } state_t;

    state_t            state_reg;
    letter_t           sweep_reg;
    letter_t           pend_letter_reg;
    logic              pend_valid_reg;
    letter_t           pair_a_reg;
    letter_t           pair_b_reg;
    pos_t              pos_a_reg;
    pos_t              pos_b_reg;
    letter_t           out_reg;
    letter_t           y_reg;
    letter_t           filler_reg;
    logic [ALPHA_SIZE-1:0] used_reg;

    logic       accept;
    action_t    action;
    letter_t    in_letter;
    letter_t    text_letter;
    letter_t    filler_eff;
    letter_t    used_idx;
    logic       used_hit;
    logic       same_row;
    logic       same_col;
    cell_cmd_t  cmd;
    query_t     query;
    chain_res_t res;

    assign s_axis_tready = (state_reg == ST_IDLE);
    assign accept        = s_axis_tvalid && s_axis_tready;
    assign action        = action_t'(s_axis_tuser);
    assign in_letter     = s_axis_tdata[4:0];
    assign text_letter   = (in_letter == LETTER_J) ? LETTER_I : in_letter;

    always_comb
    begin
        filler_eff = (filler_reg > LETTER_Z) ? LETTER_Z : filler_reg;
        if (filler_eff == LETTER_J)
        begin
            filler_eff = LETTER_I;
        end
    end

    assign used_idx = (state_reg == ST_FILL) ? sweep_reg : in_letter;
    assign used_hit = (used_idx < LETTER_LIMIT) && used_reg[used_idx];

    always_comb
    begin
        cmd.clear  = accept && (action == ACT_CLEAR);
        cmd.letter = used_idx;
        cmd.load   = !used_hit && !res.full && (used_idx < LETTER_LIMIT) &&
                     ((accept && action == ACT_KEY) || state_reg == ST_FILL);
    end

    assign same_row = (pos_a_reg.row == pos_b_reg.row);
    assign same_col = (pos_a_reg.col == pos_b_reg.col);

    always_comb
    begin
        query.find_a = pair_a_reg;
        query.find_b = pair_b_reg;
        if (same_row)
        begin
            query.rd_x = cell_index(pos_a_reg.row, wrap_inc(pos_a_reg.col));
            query.rd_y = cell_index(pos_b_reg.row, wrap_inc(pos_b_reg.col));
        end
        else if (same_col)
        begin
            query.rd_x = cell_index(wrap_inc(pos_a_reg.row), pos_a_reg.col);
            query.rd_y = cell_index(wrap_inc(pos_b_reg.row), pos_b_reg.col);
        end
        else
        begin
            query.rd_x = cell_index(pos_a_reg.row, pos_b_reg.col);
            query.rd_y = cell_index(pos_b_reg.row, pos_a_reg.col);
        end
    end

    pf_chain u_chain (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (cmd),
        .query (query),
        .res   (res)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            used_reg <= USED_INIT;
        end
        else if (cmd.clear)
        begin
            used_reg <= USED_INIT;
        end
        else if (cmd.load)
        begin
            used_reg[cmd.letter] <= 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_IDLE;
            sweep_reg       <= '0;
            pend_letter_reg <= '0;
            pend_valid_reg  <= 1'b0;
            pair_a_reg      <= '0;
            pair_b_reg      <= '0;
            pos_a_reg       <= '0;
            pos_b_reg       <= '0;
            out_reg         <= '0;
            y_reg           <= '0;
        end
        else
        begin
            unique case (state_reg)
                ST_IDLE:
                begin
                    if (accept)
                    begin
                        unique case (action)
                            ACT_CLEAR:
                            begin
                                pend_valid_reg <= 1'b0;
                                pend_letter_reg <= '0;
                            end
                            ACT_FINISH:
                            begin
                                sweep_reg <= '0;
                                state_reg <= ST_FILL;
                            end
                            ACT_TEXT:
                            begin
                                if (in_letter < LETTER_LIMIT)
                                begin
                                    if (!pend_valid_reg)
                                    begin
                                        pend_letter_reg <= text_letter;
                                        pend_valid_reg  <= 1'b1;
                                    end
                                    else
                                    begin
                                        pair_a_reg     <= pend_letter_reg;
                                        pair_b_reg     <= text_letter;
                                        pend_valid_reg <= 1'b0;
                                        state_reg      <= ST_FIND;
                                    end
                                end
                            end
                            ACT_END:
                            begin
                                if (pend_valid_reg)
                                begin
                                    pair_a_reg     <= pend_letter_reg;
                                    pair_b_reg     <= filler_eff;
                                    pend_valid_reg <= 1'b0;
                                    state_reg      <= ST_FIND;
                                end
                            end
                            default:
                            begin
                            end
                        endcase
                    end
                end
                ST_FILL:
                begin
                    sweep_reg <= sweep_reg + 5'd1;
                    if (sweep_reg == LETTER_Z)
                    begin
                        state_reg <= ST_IDLE;
                    end
                end
                ST_FIND:
                begin
                    pos_a_reg <= res.pos_a;
                    pos_b_reg <= res.pos_b;
                    state_reg <= ST_SELECT;
                end
                ST_SELECT:
                begin
                    out_reg   <= res.x_data;
                    y_reg     <= (same_row && pair_a_reg == pair_b_reg) ? DOLLAR_MARK
                                                                        : res.y_data;
                    state_reg <= ST_OUT0;
                end
                ST_OUT0:
                begin
                    if (m_axis_tready)
                    begin
                        out_reg   <= y_reg;
                        state_reg <= ST_OUT1;
                    end
                end
                ST_OUT1:
                begin
                    if (m_axis_tready)
                    begin
                        state_reg <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign m_axis_tvalid = (state_reg == ST_OUT0) || (state_reg == ST_OUT1);
    assign m_axis_tdata  = {3'b000, out_reg};
    assign m_axis_tlast  = (state_reg == ST_OUT1);

    // APB register file
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            filler_reg <= FILLER_RESET;
        end
        else if (psel && penable && pwrite && pready && paddr[ADDR_W-1] == REG_FILLER)
        begin
            filler_reg <= pwdata[4:0];
        end
    end

    assign pready = 1'b1;
    assign prdata = (paddr[ADDR_W-1] == REG_FILLER) ? {27'd0, filler_reg} : 32'd0;

endmodule

// ===== rtl/core/pf_cell.sv =====
// pf_cell: one key square cell; holds a letter and its valid flag.
// Takes the fill token from its left neighbor. Depends on pf_pkg.
module pf_cell (
    input  logic              clk,
    input  logic              rst_n,
    input  pf_pkg::idx_t      id,
    input  logic              prev_valid,
    input  pf_pkg::cell_cmd_t cmd,
    input  pf_pkg::query_t    query,
    output pf_pkg::cell_out_t cout
);
    import pf_pkg::*;

    letter_t letter_reg;
    logic    valid_reg;
    logic    take;

    assign take = cmd.load && prev_valid && !valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (cmd.clear)
        begin
            valid_reg <= 1'b0;
        end
        else if (take)
        begin
            valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            letter_reg <= cmd.letter;
        end
    end

    always_comb
    begin
        cout.valid   = valid_reg;
        cout.match_a = valid_reg && (letter_reg == query.find_a);
        cout.match_b = valid_reg && (letter_reg == query.find_b);
        cout.x_data  = (valid_reg && query.rd_x == id) ? letter_reg : '0;
        cout.y_data  = (valid_reg && query.rd_y == id) ? letter_reg : '0;
    end

endmodule

// ===== rtl/core/pf_chain.sv =====
// pf_chain: row of 25 pf_cell instances forming the 5x5 key square.
// Fill token ripples cell to cell; lookups and reads are broadcast. Depends on pf_pkg.
module pf_chain (
    input  logic               clk,
    input  logic               rst_n,
    input  pf_pkg::cell_cmd_t  cmd,
    input  pf_pkg::query_t     query,
    output pf_pkg::chain_res_t res
);
    import pf_pkg::*;

    cell_out_t cells [CELL_COUNT];

    genvar g;
    generate
        for (g = 0; g < CELL_COUNT; g++)
        begin : g_cell
            pf_cell u_cell (
                .clk        (clk),
                .rst_n      (rst_n),
                .id         (idx_t'(g)),
                .prev_valid ((g == 0) ? 1'b1 : cells[(g == 0) ? 0 : g - 1].valid),
                .cmd        (cmd),
                .query      (query),
                .cout       (cells[g])
            );
        end
    endgenerate

    // letters in valid cells are unique, so at most one match per letter
    always_comb
    begin
        res = '0;
        for (int i = 0; i < CELL_COUNT; i++)
        begin
            res.pos_a.row = res.pos_a.row | (cells[i].match_a ? coord_t'(i / CELL_SIDE) : '0);
            res.pos_a.col = res.pos_a.col | (cells[i].match_a ? coord_t'(i % CELL_SIDE) : '0);
            res.pos_b.row = res.pos_b.row | (cells[i].match_b ? coord_t'(i / CELL_SIDE) : '0);
            res.pos_b.col = res.pos_b.col | (cells[i].match_b ? coord_t'(i % CELL_SIDE) : '0);
            res.x_data    = res.x_data | cells[i].x_data;
            res.y_data    = res.y_data | cells[i].y_data;
        end
        res.full = cells[CELL_COUNT - 1].valid;
    end

endmodule

// ===== rtl/core/pf_checker.sv =====
// pf_checker: port-level assertions for playfair_encryptor_top.
// Bound to the top level below; depends on pf_pkg.
module pf_checker (
    input logic                      clk,
    input logic                      rst_n,
    input logic                      s_axis_tvalid,
    input logic                      s_axis_tready,
    input logic [7:0]                s_axis_tdata,
    input logic [2:0]                s_axis_tuser,
    input logic                      m_axis_tvalid,
    input logic                      m_axis_tready,
    input logic [7:0]                m_axis_tdata,
    input logic                      m_axis_tlast,
    input logic                      psel,
    input logic                      penable,
    input logic                      pwrite,
    input logic [pf_pkg::ADDR_W-1:0] paddr,
    input logic [31:0]               pwdata,
    input logic [31:0]               prdata,
    input logic                      pready
);
    import pf_pkg::*;

    // second letter of a pair follows the first at once
    a_pair_second: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tready && !m_axis_tlast |=> m_axis_tvalid && m_axis_tlast)
        else $error("pair second word missing");

    // one word in work at a time
    a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
        !(s_axis_tready && m_axis_tvalid))
        else $error("input taken while output pending");

    a_range: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> m_axis_tdata <= 8'(DOLLAR_MARK))
        else $error("cipher word out of range");

    a_pair_done: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tready && m_axis_tlast |=> !m_axis_tvalid && s_axis_tready)
        else $error("no return to idle after pair");

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("stalled output word changed");

endmodule

bind playfair_encryptor_top pf_checker u_pf_checker (.*);

// ===== tb/playfair_encryptor_top_tb.sv =====
// playfair_encryptor_top_tb: self-checking bench for the Playfair encryptor.
// Drives key/text words on the input stream and the filler register over APB,
// scores every cipher word against an in-bench square model. Needs pf_pkg, top.
`timescale 1ns / 1ps

module playfair_encryptor_top_tb;
    import pf_pkg::*;

    localparam int CLK_HALF       = 10;
    localparam int SETTLE_CYCLES  = 40;
    localparam int WATCHDOG_LIMIT = 3000;
    localparam int REPORT_MAX     = 10;
    localparam int PHASE_WORDS    = 400;
    localparam int HOLD_CYCLES    = 400;
    localparam logic [2:0] ACT_RSVD_LO = 3'd5;
    localparam logic [2:0] ACT_RSVD_HI = 3'd7;

    typedef struct packed {
        letter_t letter;
        logic    last;
    } cipher_word_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata = 8'd0;   // [4:0] letter
    logic [2:0]  s_axis_tuser = 3'd0;   // [2:0] action
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [7:0]  m_axis_tdata;          // [4:0] cipher_letter
    logic        m_axis_tlast;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [ADDR_W-1:0] paddr = '0;
    logic [31:0] pwdata = 32'd0;
    logic [31:0] prdata;
    logic        pready;

    cipher_word_t cipher_q[$];

    letter_t sq_cell [CELL_COUNT];
    logic    sq_used [ALPHA_SIZE];
    int      sq_fill;
    letter_t held_letter;
    logic    held_valid;
    letter_t filler_reg;

    int src_gap_pct = 0;
    int snk_stall_pct = 0;
    int hold_start = 0;
    int hold_left = 0;
    int errors = 0;
    int idle_cycles = 0;
    int words_sent = 0;

    playfair_encryptor_top u_top (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    initial
    begin
        forever #CLK_HALF clk = ~clk;
    end

    // ---------------- square model ----------------

    task automatic clear_square();
        for (int i = 0; i < ALPHA_SIZE; i++)
            sq_used[i] = 1'b0;
        sq_used[LETTER_J] = 1'b1;
        sq_fill = 0;
        held_letter = '0;
        held_valid = 1'b0;
    endtask

    function automatic letter_t cell_at(int idx);
        return (idx < sq_fill) ? sq_cell[idx] : letter_t'(0);
    endfunction

    // letters missing from the valid part of the square sit at row 0, column 0
    function automatic int locate(letter_t l);
        for (int i = 0; i < sq_fill; i++)
            if (sq_cell[i] == l)
                return i;
        return 0;
    endfunction

    task automatic encrypt_pair(letter_t a, letter_t b);
        int pa, pb, r1, c1, r2, c2;
        letter_t x, y;
        pa = locate(a);
        pb = locate(b);
        r1 = pa / CELL_SIDE;
        c1 = pa % CELL_SIDE;
        r2 = pb / CELL_SIDE;
        c2 = pb % CELL_SIDE;
        if (r1 == r2)
        begin
            x = cell_at(r1 * CELL_SIDE + (c1 + 1) % CELL_SIDE);
            y = (a == b) ? DOLLAR_MARK : cell_at(r2 * CELL_SIDE + (c2 + 1) % CELL_SIDE);
        end
        else if (c1 == c2)
        begin
            x = cell_at(((r1 + 1) % CELL_SIDE) * CELL_SIDE + c1);
            y = cell_at(((r2 + 1) % CELL_SIDE) * CELL_SIDE + c2);
        end
        else
        begin
            x = cell_at(r1 * CELL_SIDE + c2);
            y = cell_at(r2 * CELL_SIDE + c1);
        end
        cipher_q.push_back({x, 1'b0});
        cipher_q.push_back({y, 1'b1});
    endtask

    task automatic apply_word(logic [2:0] act, letter_t l);
        letter_t t, f;
        case (act)
            ACT_CLEAR:
                clear_square();
            ACT_KEY:
                if (l < LETTER_LIMIT && !sq_used[l] && sq_fill < CELL_COUNT)
                begin
                    sq_cell[sq_fill] = l;
                    sq_used[l] = 1'b1;
                    sq_fill++;
                end
            ACT_FINISH:
                for (int m = 0; m < ALPHA_SIZE; m++)
                    if (!sq_used[m] && sq_fill < CELL_COUNT)
                    begin
                        sq_cell[sq_fill] = letter_t'(m);
                        sq_used[m] = 1'b1;
                        sq_fill++;
                    end
            ACT_TEXT:
                if (l < LETTER_LIMIT)
                begin
                    t = (l == LETTER_J) ? LETTER_I : l;
                    if (!held_valid)
                    begin
                        held_letter = t;
                        held_valid = 1'b1;
                    end
                    else
                    begin
                        held_valid = 1'b0;
                        encrypt_pair(held_letter, t);
                    end
                end
            ACT_END:
            begin
                f = (filler_reg > LETTER_Z) ? LETTER_Z : filler_reg;
                if (f == LETTER_J)
                    f = LETTER_I;
                if (held_valid)
                begin
                    held_valid = 1'b0;
                    encrypt_pair(held_letter, f);
                end
            end
            default:
                ;
        endcase
    endtask

    // ---------------- drivers ----------------

    task automatic send_word(logic [2:0] act, letter_t l);
        while ($urandom_range(0, 99) < src_gap_pct)
        begin
            s_axis_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= act;
        s_axis_tdata  <= {3'b000, l};
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        apply_word(act, l);
        words_sent++;
    endtask

    task automatic settle();
        s_axis_tvalid <= 1'b0;
        while (cipher_q.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_filler(letter_t v);
        psel    <= 1'b1;
        pwrite  <= 1'b1;
        penable <= 1'b0;
        paddr   <= {REG_FILLER, 2'b00};
        pwdata  <= {27'd0, v};
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        filler_reg = v;
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    function automatic letter_t any_letter();
        return letter_t'($urandom_range(0, 31));
    endfunction

    function automatic letter_t pick_key();
        if ($urandom_range(0, 9) == 0)
            return letter_t'($urandom_range(26, 31));
        return letter_t'($urandom_range(0, 25));
    endfunction

    // biased toward repeats so doubled pairs show up often
    function automatic letter_t pick_text(letter_t prev);
        int r;
        r = $urandom_range(0, 99);
        if (r < 5)
            return letter_t'($urandom_range(26, 31));
        if (r < 15)
            return prev;
        return letter_t'($urandom_range(0, 25));
    endfunction

    task automatic run_session();
        int n;
        letter_t prev;
        if ($urandom_range(0, 99) < 15)
        begin
            n = $urandom_range(1, 6);
            repeat (n) send_word(3'($urandom_range(0, 7)), any_letter());
        end
        else
        begin
            send_word(ACT_CLEAR, any_letter());
            n = $urandom_range(0, 12);
            repeat (n) send_word(ACT_KEY, pick_key());
            if ($urandom_range(0, 9) != 0)
                send_word(ACT_FINISH, any_letter());
            n = $urandom_range(2, 30);
            prev = '0;
            repeat (n)
            begin
                prev = pick_text(prev);
                send_word(ACT_TEXT, prev);
            end
            if ($urandom_range(0, 4) != 0)
                send_word(ACT_END, any_letter());
        end
    endtask

    // ---------------- tests ----------------

    task automatic test_directed();
        send_word(ACT_CLEAR, 5'd0);
        send_word(ACT_KEY, 5'd15);
        send_word(ACT_KEY, 5'd11);
        send_word(ACT_KEY, 5'd0);
        send_word(ACT_KEY, 5'd24);
        send_word(ACT_KEY, 5'd5);
        send_word(ACT_KEY, LETTER_J);
        send_word(ACT_KEY, 5'd0);
        send_word(ACT_KEY, 5'd26);
        send_word(ACT_KEY, 5'd31);
        // partial square: D is not in it yet
        send_word(ACT_TEXT, 5'd3);
        send_word(ACT_TEXT, 5'd0);
        send_word(ACT_FINISH, 5'd0);
        send_word(ACT_FINISH, 5'd31);
        send_word(ACT_KEY, 5'd25);
        send_word(ACT_TEXT, 5'd7);
        send_word(ACT_TEXT, 5'd4);
        send_word(ACT_TEXT, 5'd11);
        send_word(ACT_TEXT, 5'd11);
        send_word(ACT_TEXT, 5'd15);
        send_word(ACT_TEXT, 5'd30);
        send_word(ACT_TEXT, LETTER_J);
        send_word(ACT_RSVD_LO, 5'd3);
        send_word(ACT_RSVD_HI, 5'd31);
        send_word(ACT_TEXT, 5'd25);
        send_word(ACT_END, 5'd0);
        send_word(ACT_END, 5'd0);
    endtask

    task automatic test_fill_letter();
        letter_t fills [6];
        letter_t same;
        fills = '{5'd0, 5'd9, 5'd25, 5'd26, 5'd31, 5'd23};
        foreach (fills[i])
        begin
            settle();
            write_filler(fills[i]);
            send_word(ACT_CLEAR, 5'd0);
            send_word(ACT_FINISH, 5'd0);
            send_word(ACT_TEXT, letter_t'($urandom_range(0, 25)));
            send_word(ACT_END, 5'd0);
            // held letter equal to the effective filler
            same = (fills[i] > LETTER_Z) ? LETTER_Z :
                   (fills[i] == LETTER_J) ? LETTER_I : fills[i];
            send_word(ACT_TEXT, same);
            send_word(ACT_END, 5'd0);
        end
    endtask

    task automatic test_random_traffic();
        int gaps [4];
        int stalls [4];
        int target;
        gaps   = '{0, 49, 0, 17};
        stalls = '{0, 0, 49, 17};
        for (int p = 0; p < 4; p++)
        begin
            settle();
            write_filler(letter_t'($urandom_range(0, 31)));
            src_gap_pct   = gaps[p];
            snk_stall_pct = stalls[p];
            target = words_sent + PHASE_WORDS;
            while (words_sent < target)
                run_session();
        end
    endtask

    task automatic test_stall_fill();
        settle();
        src_gap_pct   = 0;
        snk_stall_pct = 0;
        send_word(ACT_CLEAR, 5'd0);
        repeat (5) send_word(ACT_KEY, letter_t'($urandom_range(0, 25)));
        send_word(ACT_FINISH, 5'd0);
        hold_start = HOLD_CYCLES;
        repeat (40) send_word(ACT_TEXT, letter_t'($urandom_range(0, 25)));
    endtask

    // ---------------- receiver, scoreboard, watchdog ----------------

    always @(posedge clk)
    begin
        if (hold_start != 0)
        begin
            hold_left = hold_start;
            hold_start = 0;
        end
        if (hold_left > 0)
        begin
            hold_left--;
            m_axis_tready <= 1'b0;
        end
        else
            m_axis_tready <= ($urandom_range(0, 99) >= snk_stall_pct);
    end

    always @(posedge clk)
    begin
        cipher_word_t want;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            if (cipher_q.size() == 0)
            begin
                errors++;
                if (errors <= REPORT_MAX)
                    $display("ERROR: unexpected word letter %0d last %0b",
                             m_axis_tdata, m_axis_tlast);
            end
            else
            begin
                want = cipher_q.pop_front();
                if (m_axis_tdata !== {3'b000, want.letter} || m_axis_tlast !== want.last)
                begin
                    errors++;
                    if (errors <= REPORT_MAX)
                        $display("ERROR: expected letter %0d last %0b, got letter %0d last %0b",
                                 want.letter, want.last, m_axis_tdata, m_axis_tlast);
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)
            || (psel && penable))
            idle_cycles <= 0;
        else if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("playfair_encryptor_top_tb: errors");
            $finish;
        end
        else
            idle_cycles <= idle_cycles + 1;
    end

    initial
    begin
        for (int i = 0; i < CELL_COUNT; i++)
            sq_cell[i] = '0;
        clear_square();
        filler_reg = FILLER_RESET;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed();
        test_fill_letter();
        test_random_traffic();
        test_stall_fill();

        settle();
        if (errors == 0)
            $display("playfair_encryptor_top_tb: clean");
        else
            $display("playfair_encryptor_top_tb: errors");
        $finish;
    end

endmodule
